// ===== rtl/tblf_pkg.sv =====
// Package with the sizes, opcodes and interface structs of the byte log FIFO.
package tblf_pkg;

    localparam int LOG_BYTES = 65536;
    localparam int ADDR_W    = $clog2(LOG_BYTES);
    localparam int COUNT_W   = 16;
    localparam int DATA_W    = 8;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [DATA_W-1:0]  t_byte;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_COMMIT = 2'd2,
        OP_ABORT  = 2'd3
    } t_opcode;

    // Request from the pointer logic to the byte store.
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    // Result control that travels alongside the store read data.
    typedef struct packed {
        logic   strobe;
        logic   read_valid;
        t_count avail;
    } t_result;

endpackage

// ===== rtl/tblf_store.sv =====
// Byte store of the log: one write port and one registered read port.
module tblf_store (
    input  logic              i_clk,
    input  tblf_pkg::t_mem_req i_req,
    output tblf_pkg::t_byte   o_q
);
    import tblf_pkg::*;

    t_byte r_mem [LOG_BYTES];
    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/tblf_ctrl.sv =====
// Pointer registers, opcode decode and available count of the byte log.
module tblf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_opcode,
    input  tblf_pkg::t_byte    i_data_byte,
    output tblf_pkg::t_mem_req o_req,
    output tblf_pkg::t_result  o_result
);
    import tblf_pkg::*;

    localparam logic [ADDR_W:0] SIZE     = (ADDR_W+1)'(LOG_BYTES);
    localparam t_addr           LAST_POS = ADDR_W'(LOG_BYTES - 1);

    t_addr   r_wr_pos, n_wr_pos;
    t_addr   r_rd_pos, n_rd_pos;
    t_addr   r_cm_pos, n_cm_pos;
    t_result r_result, n_result;

    logic [ADDR_W:0] new_diff;
    logic [ADDR_W:0] new_avail;
    logic            not_empty;
    logic            read_hit;
    t_opcode         op;

    function automatic t_addr next_pos(input t_addr p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    assign op        = t_opcode'(i_opcode);
    assign not_empty = (r_wr_pos != r_rd_pos);

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        n_cm_pos = r_cm_pos;
        o_req    = '0;
        o_req.waddr = r_wr_pos;
        o_req.wdata = i_data_byte;
        o_req.raddr = r_rd_pos;
        read_hit = 1'b0;
        if (i_accept) begin
            unique case (op)
                OP_APPEND: begin
                    o_req.we = 1'b1;
                    n_wr_pos = next_pos(r_wr_pos);
                end
                OP_READ: begin
                    if (not_empty) begin
                        o_req.re = 1'b1;
                        read_hit = 1'b1;
                        n_rd_pos = next_pos(r_rd_pos);
                    end
                end
                OP_COMMIT: n_cm_pos = r_rd_pos;
                OP_ABORT:  n_rd_pos = r_cm_pos;
                default:   n_rd_pos = r_rd_pos;
            endcase
        end
    end

    // Count after the operation; a negative difference wraps by the log size.
    assign new_diff  = {1'b0, n_wr_pos} - {1'b0, n_rd_pos};
    assign new_avail = new_diff[ADDR_W] ? new_diff + SIZE : new_diff;

    always_comb begin
        n_result.strobe     = i_accept;
        n_result.read_valid = read_hit;
        n_result.avail      = COUNT_W'(new_avail[ADDR_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_cm_pos <= '0;
            r_result <= '0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_cm_pos <= n_cm_pos;
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== rtl/transactional_byte_log_fifo.sv =====
// Top level of the transactional byte log FIFO with read commit and rollback.
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  ------------------------
//  command   i_opcode, i_data_byte                           i_start high, o_busy low
//  result    o_read_data, o_read_valid, o_available_count    o_strobe, one cycle
//
// A transaction is accepted at any clock edge with i_start high; o_busy is
// always low, so a new command can follow in every cycle.
// The result of each transaction appears in the cycle after acceptance; the
// result control is registered in the controller, the byte in the store's read port.
// Reset is synchronous and active low; it clears the three positions and
// the result strobe. The store itself is not cleared and needs no sweep.
// The receiver cannot stall, so results are never held back.
module transactional_byte_log_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_strobe,
    output logic [7:0] o_read_data,
    output logic       o_read_valid,
    output logic [15:0] o_available_count
);
    import tblf_pkg::*;

    t_mem_req mem_req;
    t_result  result;
    t_byte    mem_q;
    logic     accept;

    // Every command completes its store access at its accepting edge, and a
    // write followed by a read of the same entry lands in order because the
    // read is issued after the write edge. No interlock is needed.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    tblf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_req       (mem_req),
        .o_result    (result)
    );

    tblf_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

    // The store output holds its last value on other opcodes, so the byte is
    // masked to zero unless this transaction read one.
    assign o_strobe          = result.strobe;
    assign o_read_valid      = result.read_valid;
    assign o_read_data       = result.read_valid ? mem_q : '0;
    assign o_available_count = result.avail;

    // A result follows every accepted transaction in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction in the previous cycle.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept))
        else $error("result without an accepted transaction");

    // A returned byte only comes from a read transaction.
    a_valid_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_read_valid |-> (o_strobe && $past(i_opcode) == OP_READ))
        else $error("read_valid on a non-read transaction");

    // An append never returns a byte.
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_APPEND) |=> !o_read_valid)
        else $error("append reported a read byte");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the transactional byte log FIFO: directed table, random transactions.
module tb_top;

    import tblf_pkg::*;

    // One result transaction as the block reports it.
    typedef struct packed {
        t_byte  data;
        logic   valid;
        t_count count;
    } log_result_t;

    // One row of the directed table. When typed is set, the row carries its own
    // expected result; otherwise the mirror of the log supplies it.
    typedef struct packed {
        t_opcode     op;
        t_byte       data;
        logic        typed;
        log_result_t result;
    } dir_row_t;

    localparam int     CLK_HALF      = 6;
    localparam int     RESET_CYCLES  = 5;
    localparam int     RANDOM_ITEMS  = 600;
    localparam int     DRAIN_EVERY   = 150;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     LIMIT_CYCLES  = 1_500_000;
    localparam int     MAX_REPORTS   = 100;
    localparam int     IDLE_PCT      = 34;

    // Every input starts at a known value; reset is held low from time zero.
    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_start     = 1'b0;
    t_opcode i_opcode    = OP_APPEND;
    t_byte   i_data_byte = '0;

    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_read_data;
    logic        o_read_valid;
    logic [15:0] o_available_count;

    transactional_byte_log_fifo i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .o_strobe          (o_strobe),
        .o_read_data       (o_read_data),
        .o_read_valid      (o_read_valid),
        .o_available_count (o_available_count)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // The watchdog ends a run that hangs, for example when results stop coming.
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // Mirror of the log. The positions are 16 bits wide, so they wrap at the
    // store size by themselves, exactly as the block's pointers do. The mirror
    // starts in the reset state, and reset is applied only once.
    t_byte mirror_mem [LOG_BYTES];
    t_addr mirror_wr     = '0;
    t_addr mirror_rd     = '0;
    t_addr mirror_commit = '0;

    function automatic t_count mirror_level();
        return t_count'(mirror_wr - mirror_rd);
    endfunction

    // Applies one command to the mirror and returns the result it must produce.
    // An append never checks for room, so a full log silently loses its unread
    // bytes. A read on an empty log returns nothing and leaves the read position.
    function automatic log_result_t predict_log_op(t_opcode op, t_byte data);
        log_result_t res;
        res = '0;
        case (op)
            OP_APPEND: begin
                mirror_mem[mirror_wr] = data;
                mirror_wr = mirror_wr + 1'b1;
            end
            OP_READ: begin
                if (mirror_level() != '0) begin
                    res.data  = mirror_mem[mirror_rd];
                    res.valid = 1'b1;
                    mirror_rd = mirror_rd + 1'b1;
                end
            end
            OP_COMMIT: mirror_commit = mirror_rd;
            default:   mirror_rd = mirror_commit;
        endcase
        res.count = mirror_level();
        return res;
    endfunction

    // Expected results in acceptance order, the oldest at the front.
    log_result_t expected_results [$];
    int          fail_count = 0;

    // Sideband that travels with each command. It is driven by nonblocking
    // assignments together with the command, so at the accepting edge the
    // monitor sees the values that belong to the transaction being accepted.
    logic        typed_row    = 1'b0;
    log_result_t typed_result = '0;

    // Only the first mismatches are printed, which keeps a broken build from
    // flooding the log; all of them are counted.
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Monitor. The result check runs before the prediction in the same block,
    // so the order of the queue never depends on scheduling. A result is on
    // the ports for the one cycle that ends at this edge; it cannot be stalled.
    always @(posedge i_clk) begin
        log_result_t want;
        log_result_t got;
        got = '{o_read_data, o_read_valid, o_available_count};
        if (o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with none expected, expected none, actual %0h/%0b/%0h",
                             $time, got.data, got.valid, got.count);
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", 16'(want.data), 16'(got.data));
                check_field("read_valid", 16'(want.valid), 16'(got.valid));
                check_field("available_count", want.count, got.count);
            end
        end
        if (i_rst_n && i_start && o_busy === 1'b0) begin
            // The mirror always advances; a typed row only replaces the value
            // that is compared.
            want = predict_log_op(i_opcode, i_data_byte);
            if (typed_row)
                want = typed_result;
            expected_results.push_back(want);
        end
    end

    int idle_pct   = IDLE_PCT;
    int sent_count = 0;

    // Presents one command and returns at the edge that accepts it. Idle cycles
    // before it carry random junk on the payload, which the block must ignore.
    task automatic send_cmd(input t_opcode op, input t_byte data, input logic typed,
                            input log_result_t want);
        while ($urandom_range(99) < idle_pct) begin
            i_start     <= 1'b0;
            i_opcode    <= t_opcode'($urandom_range(3));
            i_data_byte <= t_byte'($urandom);
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_opcode     <= op;
        i_data_byte  <= data;
        typed_row    <= typed;
        typed_result <= want;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sent_count++;
    endtask

    // Holds the sender off until every expected result has come. The queue is
    // polled on the falling edge, away from the monitor, and the task returns
    // on a rising edge so that driving resumes in step with the clock.
    task automatic drain_results();
        i_start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        dir_row_t rows [22];
        int       first_random;
        int       next_drain;
        int       burst;
        int       reads_n;

        // Directed table. Starting from reset, it covers an empty read, commit
        // and abort with nothing logged, the byte extremes, a rollback that
        // replays bytes, a read that empties the log, and the payload byte being
        // ignored for everything but append.
        rows = '{
            '{OP_READ,   8'hFF, 1'b1, '{8'h00, 1'b0, 16'd0}},
            '{OP_COMMIT, 8'h00, 1'b1, '{8'h00, 1'b0, 16'd0}},
            '{OP_ABORT,  8'hFF, 1'b1, '{8'h00, 1'b0, 16'd0}},
            '{OP_APPEND, 8'h00, 1'b1, '{8'h00, 1'b0, 16'd1}},
            '{OP_APPEND, 8'hFF, 1'b1, '{8'h00, 1'b0, 16'd2}},
            '{OP_APPEND, 8'hA5, 1'b1, '{8'h00, 1'b0, 16'd3}},
            '{OP_COMMIT, 8'h5A, 1'b1, '{8'h00, 1'b0, 16'd3}},
            '{OP_READ,   8'h00, 1'b1, '{8'h00, 1'b1, 16'd2}},
            '{OP_READ,   8'h00, 1'b1, '{8'hFF, 1'b1, 16'd1}},
            '{OP_ABORT,  8'h00, 1'b1, '{8'h00, 1'b0, 16'd3}},
            '{OP_READ,   8'h00, 1'b1, '{8'h00, 1'b1, 16'd2}},
            '{OP_READ,   8'h00, 1'b1, '{8'hFF, 1'b1, 16'd1}},
            '{OP_COMMIT, 8'h00, 1'b1, '{8'h00, 1'b0, 16'd1}},
            '{OP_READ,   8'h00, 1'b1, '{8'hA5, 1'b1, 16'd0}},
            '{OP_READ,   8'hFF, 1'b1, '{8'h00, 1'b0, 16'd0}},
            '{OP_ABORT,  8'h00, 1'b1, '{8'h00, 1'b0, 16'd1}},
            '{OP_READ,   8'h00, 1'b1, '{8'hA5, 1'b1, 16'd0}},
            '{OP_COMMIT, 8'h00, 1'b1, '{8'h00, 1'b0, 16'd0}},
            '{OP_APPEND, 8'h80, 1'b0, '0},
            '{OP_APPEND, 8'h01, 1'b0, '0},
            '{OP_ABORT,  8'h00, 1'b0, '0},
            '{OP_READ,   8'h00, 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_cmd(rows[k].op, rows[k].data, rows[k].typed, rows[k].result);
        drain_results();

        // Random part. Most of it is well-formed transactions: a burst of
        // appends, some reads (sometimes more than are available), then a
        // commit, or an abort followed by a few replayed reads. The rest is
        // single random commands. One stretch runs without idle cycles, and the
        // sender drains the log at regular points.
        first_random = sent_count;
        next_drain   = DRAIN_EVERY;
        while (sent_count - first_random < RANDOM_ITEMS) begin
            idle_pct = (sent_count - first_random >= 250 &&
                        sent_count - first_random < 400) ? 0 : IDLE_PCT;
            if ($urandom_range(99) < 80) begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_cmd(OP_APPEND, t_byte'($urandom), 1'b0, '0);
                reads_n = $urandom_range(0, burst + 2);
                repeat (reads_n)
                    send_cmd(OP_READ, t_byte'($urandom), 1'b0, '0);
                if ($urandom_range(3) == 0) begin
                    send_cmd(OP_ABORT, t_byte'($urandom), 1'b0, '0);
                    repeat ($urandom_range(0, 2))
                        send_cmd(OP_READ, t_byte'($urandom), 1'b0, '0);
                end else begin
                    send_cmd(OP_COMMIT, t_byte'($urandom), 1'b0, '0);
                end
            end else begin
                send_cmd(t_opcode'($urandom_range(3)), t_byte'($urandom), 1'b0, '0);
            end
            if (sent_count - first_random >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
        end

        // Wait out every expected result, then let the bench settle to catch any
        // stray strobe, before the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
